// ===== hdl/wma_pkg.sv =====
package wma_pkg;

    localparam int CFG_W           = 7;
    localparam int WINDOW_AT_RESET = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic
    {
        FR_IDLE,
        FR_UPDATE
    } front_state_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_DIV,
        BK_FINISH
    } back_state_t;

endpackage

// ===== hdl/wma_front.sv =====
module wma_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int POS_W       = 6,
    parameter int CNT_W       = 7,
    parameter int SUM_W       = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [wma_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          q_full,
    output logic                          q_push,
    output logic signed [SUM_W-1:0]       q_sum,
    output logic [CNT_W-1:0]              q_count
);
    import wma_pkg::*;

    localparam int WIN_RST = (WINDOW_AT_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_AT_RESET;

    front_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic [CNT_W-1:0]        win_reg, win_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic                    accept;
    logic                    full;
    logic [CNT_W-1:0]        pos_inc;
    logic signed [SUM_W-1:0] add_term;
    logic signed [SUM_W-1:0] sub_term;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    state_next = FR_UPDATE;
                end
            end
            FR_UPDATE:
            begin
                state_next = FR_IDLE;
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_ready = !q_full;
            end
            FR_UPDATE:
            begin
                q_push = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
                q_push   = 1'b0;
            end
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign full     = (held_reg == win_reg);
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);
    assign add_term = SUM_W'(sample_reg);
    assign sub_term = full ? SUM_W'(old_reg) : '0;

    // window register and running state
    always_comb
    begin
        win_next  = win_reg;
        pos_next  = pos_reg;
        held_next = held_reg;
        sum_next  = sum_reg;
        if (cfg_wen)
        begin
            if (cfg_wdata == '0)
            begin
                win_next = CNT_W'(1);
            end
            else if (32'(cfg_wdata) > MAX_WINDOW)
            begin
                win_next = CNT_W'(MAX_WINDOW);
            end
            else
            begin
                win_next = CNT_W'(cfg_wdata);
            end
            pos_next  = '0;
            held_next = '0;
            sum_next  = '0;
        end
        else if (q_push)
        begin
            sum_next = sum_reg + add_term - sub_term;
            if (pos_inc >= win_reg)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
            if (!full)
            begin
                held_next = held_reg + CNT_W'(1);
            end
        end
    end

    assign q_sum   = sum_next;
    assign q_count = held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            win_reg   <= CNT_W'(WIN_RST);
            pos_reg   <= '0;
            held_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            sum_reg   <= sum_next;
        end
    end

    // sample store, registered read of the oldest word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_sample;
            old_reg    <= mem[pos_reg];
        end
        if (q_push)
        begin
            mem[pos_reg] <= sample_reg;
        end
    end

endmodule

// ===== hdl/wma_fifo.sv =====
module wma_fifo #(
    parameter int WIDTH = 29
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    import wma_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    assign full     = (lvl_reg == LVL_W'(QUEUE_DEPTH));
    assign empty    = (lvl_reg == '0);
    assign pop_data = slot[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        lvl_next = lvl_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            lvl_next = lvl_reg + LVL_W'(1);
        end
        else if (pop && !push)
        begin
            lvl_next = lvl_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/wma_back.sv =====
module wma_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 7,
    parameter int SUM_W       = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic signed [SUM_W-1:0]       q_sum,
    input  logic [CNT_W-1:0]              q_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_average
);
    import wma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg;

    logic             start;
    logic             load_out;
    logic             out_free;
    logic [CNT_W:0]   rem_shift;
    logic [CNT_W:0]   rem_diff;
    logic             qbit;
    logic [SUM_W-1:0] quot_signed;

    assign out_free = !valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        start    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                start = !q_empty;
            end
            BK_DIV:
            begin
                start = 1'b0;
            end
            BK_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                start    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign q_pop = start;

    // one restoring step per cycle, quotient shifts in behind the dividend
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign qbit      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start)
        begin
            dvd_next  = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
        end
        else if (state_reg == BK_DIV)
        begin
            dvd_next  = {dvd_reg[SUM_W-2:0], qbit};
            rem_next  = qbit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
        end
    end

    assign quot_signed = neg_reg ? (~dvd_reg + SUM_W'(1)) : dvd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_out)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= q_count;
            neg_reg <= q_sum[SUM_W-1];
        end
        if (load_out)
        begin
            avg_reg <= quot_signed[SAMPLE_BITS-1:0];
        end
    end

    assign out_valid   = valid_reg;
    assign out_average = avg_reg;

endmodule

// ===== hdl/windowed_moving_average.sv =====
// Moving average over the most recent window_length signed samples
// (1 to MAX_WINDOW, a written zero acts as 1, larger values are clamped).
// Writing the window register restarts the average from an empty history;
// until the window has filled, the result is the mean of the samples seen so
// far. Results are truncated toward zero. Each input word yields one output
// word. The front end takes a sample by a registered read of the oldest
// stored sample, then the sum update, and accepts no new sample until the
// update is done; it hands the sum to a 2-entry queue. The back end divides
// it with a one-bit-per-cycle restoring divider and pops the next queued
// word only after the result of the last one is loaded into the output
// register.
module windowed_moving_average #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [wma_pkg::CFG_W-1:0]             cfg_wdata,     // window_length
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata   // average
);
    import wma_pkg::*;

    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int TD_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ENT_W  = SUM_W + CNT_W;

    logic                          q_full;
    logic                          q_empty;
    logic                          q_push;
    logic                          q_pop;
    logic signed [SUM_W-1:0]       push_sum;
    logic [CNT_W-1:0]              push_count;
    logic [ENT_W-1:0]              pop_data;
    logic signed [SAMPLE_BITS-1:0] average;

    wma_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_sum     (push_sum),
        .q_count   (push_count)
    );

    wma_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_count, push_sum}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    wma_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_sum       (pop_data[SUM_W-1:0]),
        .q_count     (pop_data[ENT_W-1:SUM_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_average (average)
    );

    assign m_axis_tdata = TD_W'(unsigned'(average));

endmodule
